>>> sv/swm_pkg.sv
// Shared constants and controller/datapath interface types for the two-way merge.
`timescale 1ns / 1ps
package swm_pkg;

  localparam int LIST_DEPTH = 32;
  localparam int IDX_W      = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
  localparam int DATA_W     = 32;

  localparam logic [1:0] OP_PUSH_A = 2'd0;
  localparam logic [1:0] OP_PUSH_B = 2'd1;
  localparam logic [1:0] OP_MERGE  = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_UNSORTED = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;
  localparam logic [1:0] ST_OVERFLOW = 2'd3;

  typedef struct packed {
    logic push_a;
    logic push_b;
    logic merge_init;
    logic emit_status;
    logic emit_elem;
  } swm_cmd_t;

  typedef struct packed {
    logic special;     // overflow, unsorted or both empty: one status item
    logic last_elem;   // element chosen this cycle ends the merge
  } swm_sts_t;

endpackage

>>> sv/swm_ctrl.sv
// Sequencer for push, merge and emit phases of the two-way merge.
`timescale 1ns / 1ps
module swm_ctrl import swm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  logic [1:0] operation_i,
  input  swm_sts_t   sts_i,
  output swm_cmd_t   cmd_o,
  output logic       busy_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_CMP  = 2'd2;

  logic [1:0] state_q, state_d;
  logic       accept;

  assign accept = start_i && (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (operation_i)
            OP_PUSH_A: cmd_o.push_a = 1'b1;
            OP_PUSH_B: cmd_o.push_b = 1'b1;
            OP_MERGE: begin
              if (sts_i.special) begin
                cmd_o.emit_status = 1'b1;
              end else begin
                cmd_o.merge_init = 1'b1;
                state_d          = S_READ;
              end
            end
            default: ;
          endcase
        end
      end
      // heads are read from the stores during this cycle
      S_READ: state_d = S_CMP;
      S_CMP: begin
        cmd_o.emit_elem = 1'b1;
        state_d         = sts_i.last_elem ? S_IDLE : S_READ;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

>>> sv/swm_dp.sv
// List stores, sortedness tracking, merge pointers and result registers.
`timescale 1ns / 1ps
module swm_dp import swm_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic signed [DATA_W-1:0] element_value_i,
  input  swm_cmd_t                 cmd_i,
  output swm_sts_t                 sts_o,
  output logic                     result_valid_o,
  output logic signed [DATA_W-1:0] merged_value_o,
  output logic [1:0]               status_o,
  output logic                     last_of_run_o
);

  logic signed [DATA_W-1:0] mem_a [LIST_DEPTH];
  logic signed [DATA_W-1:0] mem_b [LIST_DEPTH];

  logic [CNT_W-1:0]         cnt_a_q, cnt_b_q, ia_q, ib_q;
  logic signed [DATA_W-1:0] prev_a_q, prev_b_q;
  logic                     sorted_a_q, sorted_b_q, ovf_q;
  logic signed [DATA_W-1:0] rd_a_q, rd_b_q;

  logic                     out_valid_q;
  logic signed [DATA_W-1:0] out_value_q;
  logic [1:0]               out_status_q;
  logic                     out_last_q;

  logic                     full_a, full_b, take_a, do_clear;
  logic [CNT_W-1:0]         ia_nx, ib_nx;
  logic [1:0]               special_code;

  assign full_a = (cnt_a_q == CNT_W'(LIST_DEPTH));
  assign full_b = (cnt_b_q == CNT_W'(LIST_DEPTH));

  assign take_a = (ia_q < cnt_a_q) && ((ib_q >= cnt_b_q) || !(rd_b_q < rd_a_q));
  assign ia_nx  = take_a ? ia_q + CNT_W'(1) : ia_q;
  assign ib_nx  = take_a ? ib_q : ib_q + CNT_W'(1);

  assign sts_o.last_elem = (ia_nx >= cnt_a_q) && (ib_nx >= cnt_b_q);
  assign sts_o.special   = ovf_q || !sorted_a_q || !sorted_b_q ||
                           ((cnt_a_q == '0) && (cnt_b_q == '0));

  always_comb begin
    if (ovf_q) begin
      special_code = ST_OVERFLOW;
    end else if (!sorted_a_q || !sorted_b_q) begin
      special_code = ST_UNSORTED;
    end else begin
      special_code = ST_EMPTY;
    end
  end

  assign do_clear = cmd_i.emit_status || (cmd_i.emit_elem && sts_o.last_elem);

  // stores: written on push, read at the merge pointers every cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.push_a && !full_a) begin
      mem_a[cnt_a_q[IDX_W-1:0]] <= element_value_i;
    end
    if (cmd_i.push_b && !full_b) begin
      mem_b[cnt_b_q[IDX_W-1:0]] <= element_value_i;
    end
    rd_a_q <= mem_a[ia_q[IDX_W-1:0]];
    rd_b_q <= mem_b[ib_q[IDX_W-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_a_q    <= '0;
      cnt_b_q    <= '0;
      prev_a_q   <= '0;
      prev_b_q   <= '0;
      sorted_a_q <= 1'b1;
      sorted_b_q <= 1'b1;
      ovf_q      <= 1'b0;
      ia_q       <= '0;
      ib_q       <= '0;
    end else if (do_clear) begin
      cnt_a_q    <= '0;
      cnt_b_q    <= '0;
      prev_a_q   <= '0;
      prev_b_q   <= '0;
      sorted_a_q <= 1'b1;
      sorted_b_q <= 1'b1;
      ovf_q      <= 1'b0;
      ia_q       <= '0;
      ib_q       <= '0;
    end else begin
      if (cmd_i.push_a) begin
        if (full_a) begin
          ovf_q <= 1'b1;
        end else begin
          if ((cnt_a_q != '0) && (element_value_i < prev_a_q)) sorted_a_q <= 1'b0;
          prev_a_q <= element_value_i;
          cnt_a_q  <= cnt_a_q + CNT_W'(1);
        end
      end
      if (cmd_i.push_b) begin
        if (full_b) begin
          ovf_q <= 1'b1;
        end else begin
          if ((cnt_b_q != '0) && (element_value_i < prev_b_q)) sorted_b_q <= 1'b0;
          prev_b_q <= element_value_i;
          cnt_b_q  <= cnt_b_q + CNT_W'(1);
        end
      end
      if (cmd_i.merge_init) begin
        ia_q <= '0;
        ib_q <= '0;
      end else if (cmd_i.emit_elem) begin
        ia_q <= ia_nx;
        ib_q <= ib_nx;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= cmd_i.emit_status || cmd_i.emit_elem;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_status) begin
      out_value_q  <= '0;
      out_status_q <= special_code;
      out_last_q   <= 1'b1;
    end else if (cmd_i.emit_elem) begin
      out_value_q  <= take_a ? rd_a_q : rd_b_q;
      out_status_q <= ST_OK;
      out_last_q   <= sts_o.last_elem;
    end
  end

  assign result_valid_o = out_valid_q;
  assign merged_value_o = out_value_q;
  assign status_o       = out_status_q;
  assign last_of_run_o  = out_last_q;

endmodule

>>> sv/sorted_two_way_merge.sv
// Top level of the two-way merge of sorted sequences.
`timescale 1ns / 1ps
// An item is taken when start_i is high and busy_o is low. Push items (operation 0
// to list A, 1 to list B) leave busy_o low, so pushes can come every cycle; each
// list holds up to 32 elements and further pushes are dropped and flagged. A merge
// item either yields a single status item in the following cycle (overflow,
// unsorted list, or both lists empty; busy_o stays low) or streams the merged
// sequence, busy_o high until the last element is on the ports: each step reads
// both list heads from the stores (registered read) and then compares and emits.
// Every result is shown for exactly one cycle with result_valid_o high and must be
// captured then; the final one carries last_of_run_o. Both lists are empty again
// after any merge.
module sorted_two_way_merge import swm_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  output logic                     busy_o,
  input  logic [1:0]               operation_i,
  input  logic signed [DATA_W-1:0] element_value_i,
  output logic                     result_valid_o,
  output logic signed [DATA_W-1:0] merged_value_o,
  output logic [1:0]               status_o,
  output logic                     last_of_run_o
);

  swm_cmd_t cmd;
  swm_sts_t sts;

  swm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .operation_i (operation_i),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .busy_o      (busy_o)
  );

  swm_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .element_value_i (element_value_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .result_valid_o  (result_valid_o),
    .merged_value_o  (merged_value_o),
    .status_o        (status_o),
    .last_of_run_o   (last_of_run_o)
  );

`ifndef SYNTHESIS
  // status-only items always end their run
  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && (status_o != ST_OK)) |-> last_of_run_o)
    else $error("status item without last_of_run");

  // leaving the merge phase coincides with the final element on the ports
  a_merge_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_o) |-> (result_valid_o && last_of_run_o && (status_o == ST_OK)))
    else $error("merge ended without final element");

  // a result seen while idle must be the final item of its run
  a_idle_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !busy_o) |-> last_of_run_o)
    else $error("non-final item while idle");

  // a result shown while busy is never followed by another back to back
  a_spacing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && busy_o) |=> !result_valid_o)
    else $error("merged elements back to back");
`endif

endmodule

>>> verif/testbench.sv
// Self-checking testbench for the two-way merge of sorted sequences.
`timescale 1ns / 1ps
module testbench;
  import swm_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam longint ELEM_MAX = 64'sd2147483647;
  localparam longint ELEM_MIN = -64'sd2147483648;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 10;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic [1:0]               status;
    logic                     last;
  } merge_out_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     start_i = 1'b0;
  logic [1:0]               operation_i = OP_PUSH_A;
  logic signed [DATA_W-1:0] element_value_i = '0;
  logic                     busy_o;
  logic                     result_valid_o;
  logic signed [DATA_W-1:0] merged_value_o;
  logic [1:0]               status_o;
  logic                     last_of_run_o;

  // shadow copy of both lists, index 0 is list A and 1 is list B
  logic signed [DATA_W-1:0] list_m [2][LIST_DEPTH];
  logic [CNT_W-1:0]         count_m [2];
  logic signed [DATA_W-1:0] prev_m [2];
  logic                     in_order_m [2];
  logic                     overflow_m;

  merge_out_t pending_merge_out[$];

  int sender_idle_pct;
  int n_items, n_list_items, n_merges, n_status_only, n_checked, n_errors;
  int idle_cycles;

  sorted_two_way_merge i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .operation_i     (operation_i),
    .element_value_i (element_value_i),
    .result_valid_o  (result_valid_o),
    .merged_value_o  (merged_value_o),
    .status_o        (status_o),
    .last_of_run_o   (last_of_run_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic void clear_lists_m();
    for (int i = 0; i < 2; i++) begin
      count_m[i] = '0;
      prev_m[i] = '0;
      in_order_m[i] = 1'b1;
    end
    overflow_m = 1'b0;
  endfunction

  // Expected effect of one accepted item on the lists and on the result stream.
  task automatic apply_list_op(input logic [1:0] op, input logic signed [DATA_W-1:0] val);
    int ia, ib, side;
    logic take_a;
    merge_out_t r;
    ia = 0;
    ib = 0;
    side = int'(op[0]);
    case (op)
      OP_PUSH_A, OP_PUSH_B: begin
        if (count_m[side] >= LIST_DEPTH) begin
          overflow_m = 1'b1;
        end else begin
          if (count_m[side] != 0 && val < prev_m[side]) in_order_m[side] = 1'b0;
          list_m[side][count_m[side]] = val;
          prev_m[side] = val;
          count_m[side] = count_m[side] + 1'b1;
        end
      end
      OP_MERGE: begin
        n_merges++;
        if (overflow_m || !in_order_m[0] || !in_order_m[1] ||
            (count_m[0] == 0 && count_m[1] == 0)) begin
          r.value = '0;
          r.last = 1'b1;
          if (overflow_m) r.status = ST_OVERFLOW;
          else if (!in_order_m[0] || !in_order_m[1]) r.status = ST_UNSORTED;
          else r.status = ST_EMPTY;
          pending_merge_out.push_back(r);
          n_status_only++;
        end else begin
          while (ia < count_m[0] || ib < count_m[1]) begin
            // ties go to list A
            take_a = (ia < count_m[0]) && (ib >= count_m[1] || !(list_m[1][ib] < list_m[0][ia]));
            if (take_a) begin
              r.value = list_m[0][ia];
              ia++;
            end else begin
              r.value = list_m[1][ib];
              ib++;
            end
            r.status = ST_OK;
            r.last = (ia + ib == count_m[0] + count_m[1]);
            pending_merge_out.push_back(r);
          end
        end
        clear_lists_m();
      end
      default: ;
    endcase
  endtask

  // Leaves start_i high on return; the next call drives it again and wait_all_results lowers it.
  task automatic send_item(input logic [1:0] op, input logic signed [DATA_W-1:0] val);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i <= 1'b1;
    operation_i <= op;
    element_value_i <= val;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    apply_list_op(op, val);
    n_items++;
    if (op != OP_UNUSED) n_list_items++;
  endtask

  task automatic wait_all_results();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending_merge_out.size() != 0) @(posedge clk_i);
  endtask

  // Next element of a non-decreasing run, clamped at the top of the range.
  function automatic longint next_value(input longint prev, input bit first, input int vmode);
    longint nv;
    if (vmode == 0) begin
      if (first) nv = longint'(int'($urandom));
      else nv = prev + longint'($urandom_range(0, 32'h1fff_ffff));
    end else if (vmode == 1) begin
      if (first) nv = longint'($urandom_range(0, 8)) - 4;
      else nv = prev + longint'($urandom_range(0, 2));
    end else begin
      if (first) nv = ELEM_MIN;
      else if ($urandom_range(0, 2) == 0) nv = prev + longint'(32'hffff_ffff >> $urandom_range(0, 31));
      else nv = prev;
    end
    if (nv > ELEM_MAX) nv = ELEM_MAX;
    return nv;
  endfunction

  // Load len_a / len_b elements interleaved, then merge. bad_list >= 0 puts one
  // descending step into that list (needs at least two elements there).
  task automatic run_batch(input int len_a, input int len_b, input int vmode, input int bad_list);
    int left[2], pos[2];
    int bad_pos, side;
    longint cur[2];
    left[0] = len_a;
    left[1] = len_b;
    pos[0] = 0;
    pos[1] = 0;
    cur[0] = 0;
    cur[1] = 0;
    bad_pos = -1;
    if (bad_list >= 0) bad_pos = $urandom_range(1, left[bad_list] - 1);
    while (left[0] + left[1] > 0) begin
      if ($urandom_range(0, 9) == 0) send_item(OP_UNUSED, $urandom);
      if (left[0] == 0) side = 1;
      else if (left[1] == 0) side = 0;
      else side = $urandom_range(0, 1);
      if (side == bad_list && pos[side] == bad_pos - 1) cur[side] = ELEM_MAX;
      else if (side == bad_list && pos[side] == bad_pos)
        cur[side] = cur[side] - 1 - longint'($urandom_range(0, 1000));
      else cur[side] = next_value(cur[side], pos[side] == 0, vmode);
      send_item(side ? OP_PUSH_B : OP_PUSH_A, cur[side][DATA_W-1:0]);
      pos[side]++;
      left[side]--;
    end
    send_item(OP_MERGE, $urandom);
  endtask

  task automatic test_directed();
    send_item(OP_MERGE, '0);
    send_item(OP_PUSH_A, 32'sh8000_0000);
    send_item(OP_PUSH_B, 32'sh8000_0000);
    send_item(OP_PUSH_A, '0);
    send_item(OP_PUSH_B, -32'sd1);
    send_item(OP_PUSH_B, 32'sh7fff_ffff);
    send_item(OP_PUSH_A, 32'sh7fff_ffff);
    send_item(OP_MERGE, 32'hffff_ffff);
    // unused code must not disturb the load
    send_item(OP_PUSH_A, 32'sd5);
    send_item(OP_UNUSED, 32'sd1);
    send_item(OP_PUSH_B, 32'sd5);
    send_item(OP_MERGE, '0);
    send_item(OP_PUSH_A, 32'sd10);
    send_item(OP_PUSH_A, 32'sd9);
    send_item(OP_PUSH_B, 32'sd1);
    send_item(OP_MERGE, '0);
    send_item(OP_PUSH_B, 32'sd3);
    send_item(OP_PUSH_B, -32'sd3);
    send_item(OP_MERGE, '0);
    send_item(OP_PUSH_B, 32'sh5555_aaaa);
    send_item(OP_MERGE, '0);
  endtask

  task automatic test_capacity();
    run_batch(LIST_DEPTH, LIST_DEPTH, 0, -1);
    wait_all_results();
    // overflow wins over an unsorted list
    run_batch(LIST_DEPTH + 1, 2, 1, 1);
    run_batch(0, LIST_DEPTH + 3, 2, -1);
    run_batch(0, 0, 0, -1);
  endtask

  task automatic test_random(input int n_wanted);
    int first_count, r, la, lb, t, bad;
    first_count = n_list_items;
    while (n_list_items - first_count < n_wanted) begin
      r = $urandom_range(0, 99);
      if (r < 6) begin
        la = 0;
        lb = 0;
      end else if (r < 84) begin
        la = $urandom_range(0, 8);
        lb = $urandom_range(0, 8);
      end else if (r < 94) begin
        la = $urandom_range(0, LIST_DEPTH);
        lb = $urandom_range(0, LIST_DEPTH);
      end else begin
        la = $urandom_range(LIST_DEPTH + 1, LIST_DEPTH + 4);
        lb = $urandom_range(0, 8);
        if ($urandom_range(0, 1)) begin
          t = la;
          la = lb;
          lb = t;
        end
      end
      bad = -1;
      if ($urandom_range(0, 99) < 12) begin
        if (la >= 2) bad = 0;
        else if (lb >= 2) bad = 1;
      end
      run_batch(la, lb, $urandom_range(0, 2), bad);
      if ($urandom_range(0, 5) == 0) wait_all_results();
    end
  endtask

  task automatic report_field(input string name, input logic signed [DATA_W-1:0] want,
                              input logic signed [DATA_W-1:0] got);
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    n_errors++;
  endtask

  always @(posedge clk_i) begin : check_results
    merge_out_t want;
    if (rst_ni && result_valid_o !== 1'b0) begin
      n_checked++;
      if (pending_merge_out.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual value=%0d status=%0d last=%0b",
                 $time, merged_value_o, status_o, last_of_run_o);
        n_errors++;
      end else begin
        want = pending_merge_out.pop_front();
        if (merged_value_o !== want.value) report_field("merged_value", want.value, merged_value_o);
        if (status_o !== want.status)
          report_field("status", DATA_W'(want.status), DATA_W'(status_o));
        if (last_of_run_o !== want.last)
          report_field("last_of_run", DATA_W'(want.last), DATA_W'(last_of_run_o));
      end
    end
  end

  // counts cycles in which neither an item nor a result is taken
  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && busy_o === 1'b0) || result_valid_o === 1'b1) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WATCHDOG_LIMIT) begin
        $display("%0t: no progress for %0d cycles, %0d results outstanding",
                 $time, WATCHDOG_LIMIT, pending_merge_out.size());
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    n_items = 0;
    n_list_items = 0;
    n_merges = 0;
    n_status_only = 0;
    n_checked = 0;
    n_errors = 0;
    idle_cycles = 0;
    sender_idle_pct = 18;
    clear_lists_m();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_capacity();
    test_random(20);
    sender_idle_pct = 46;
    test_random(20);
    sender_idle_pct = 0;
    test_random(15);
    wait_all_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (pending_merge_out.size() != 0) begin
      $display("%0d expected results never arrived", pending_merge_out.size());
      n_errors++;
    end
    $display("Sent %0d items (%0d list operations), %0d merges of which %0d status-only,",
             n_items, n_list_items, n_merges, n_status_only);
    $display("checked %0d results across empty, unsorted, overflow and full-depth merges.",
             n_checked);
    if (n_errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/swm_pkg.sv
sv/swm_ctrl.sv
sv/swm_dp.sv
sv/sorted_two_way_merge.sv
verif/testbench.sv
